/* rtl/dgp_pkg.sv */
// ----------------------------------------------------------------------------
// Dithered gradient pixel package
// Shared widths, register codes, pipeline types and the ordered-dither table.
// ----------------------------------------------------------------------------
package dgp_pkg;

  localparam int COORD_BITS_DEF = 12;

  // Configuration port
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SURFACE_ROW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_COLOR     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHALLOW_COLOR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MID_COLOR     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEEP_COLOR    = 3'd5;

  localparam int ROW_W = 12;  // frame_height, surface_row, band length and offset
  localparam int RGB_W = 24;

  localparam logic [ROW_W-1:0] FRAME_HEIGHT_RST  = 12'd240;
  localparam logic [ROW_W-1:0] SURFACE_ROW_RST   = 12'd9;
  localparam logic [RGB_W-1:0] TOP_COLOR_RST     = 24'h1E4D7A;
  localparam logic [RGB_W-1:0] SHALLOW_COLOR_RST = 24'h000000;
  localparam logic [RGB_W-1:0] MID_COLOR_RST     = 24'h000000;
  localparam logic [RGB_W-1:0] DEEP_COLOR_RST    = 24'h000000;

  // Channel arithmetic
  localparam int CH_W   = 8;
  localparam int NUM_CH = 3;
  localparam int QW     = CH_W;           // quotient never exceeds one channel
  localparam int NUM_W  = CH_W + ROW_W;   // |end - start| * offset
  localparam int THR_W  = 4;
  localparam int PIX_W  = 16;

  typedef enum logic [1:0] {
    BAND_TOP,
    BAND_MID,
    BAND_LOW
  } band_t;

  // One colour channel on its way through the divider.
  typedef struct packed {
    logic [CH_W-1:0]  base;   // start colour of the band
    logic             neg;    // end colour below start colour
    logic [NUM_W-1:0] rem;    // partial remainder
    logic [QW-1:0]    quo;    // quotient bits found so far
  } lane_t;

  // 4x4 ordered-dither thresholds, indexed by {row[1:0], column[1:0]}.
  localparam logic [THR_W-1:0] DITHER_TAB [16] = '{
    4'd0,  4'd8,  4'd2,  4'd10,
    4'd12, 4'd4,  4'd14, 4'd6,
    4'd3,  4'd11, 4'd1,  4'd9,
    4'd15, 4'd7,  4'd13, 4'd5
  };

endpackage

/* rtl/dithered_gradient_pixel_unit.sv */
// ----------------------------------------------------------------------------
// Dithered gradient pixel unit
// Maps a pixel coordinate to its dithered RGB565 background colour.
// ----------------------------------------------------------------------------
// Usage
//   A coordinate beat is taken at each rising edge with start high and busy
//   low. busy is high only while reset is applied and up to the first edge
//   after it, so in normal running a new coordinate may be offered in every
//   cycle. Each beat gives exactly one result: out_valid is high for one
//   cycle with out_pixel_rgb565, and results leave in the order the
//   coordinates came. Throughput is one pixel per clock outside reset; the
//   row blend divides by the band length in an eight-stage restoring
//   divider, one quotient bit per stage, with the three colour channels in
//   parallel lanes.
//   The receiver cannot stall the block, so there is no back-pressure path.
//   Reset empties the pipeline and loads the default gradient registers.
//   Registers are written through cfg_we/cfg_index/cfg_wdata; they should be
//   changed only while no pixel is in flight. Writes to unused indices are
//   ignored.
// ----------------------------------------------------------------------------
module dithered_gradient_pixel_unit #(
  parameter int COORD_BITS = dgp_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_we,
  input  logic [dgp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dgp_pkg::CFG_W-1:0]    cfg_wdata,
  // coordinate in
  input  logic                         start,
  output logic                         busy,
  input  logic [COORD_BITS-1:0]        in_x_pos,
  input  logic [COORD_BITS-1:0]        in_y_pos,
  // pixel out
  output logic                         out_valid,
  output logic [dgp_pkg::PIX_W-1:0]    out_pixel_rgb565
);

  import dgp_pkg::*;

  localparam int YW = (COORD_BITS > ROW_W) ? COORD_BITS : ROW_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [ROW_W-1:0] frame_height_r;
  logic [ROW_W-1:0] surface_row_r;
  logic [RGB_W-1:0] top_color_r;
  logic [RGB_W-1:0] shallow_color_r;
  logic [RGB_W-1:0] mid_color_r;
  logic [RGB_W-1:0] deep_color_r;
  logic             busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_height_r  <= FRAME_HEIGHT_RST;
      surface_row_r   <= SURFACE_ROW_RST;
      top_color_r     <= TOP_COLOR_RST;
      shallow_color_r <= SHALLOW_COLOR_RST;
      mid_color_r     <= MID_COLOR_RST;
      deep_color_r    <= DEEP_COLOR_RST;
      busy_r          <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FRAME_HEIGHT:  frame_height_r  <= cfg_wdata[ROW_W-1:0];
          REG_SURFACE_ROW:   surface_row_r   <= cfg_wdata[ROW_W-1:0];
          REG_TOP_COLOR:     top_color_r     <= cfg_wdata[RGB_W-1:0];
          REG_SHALLOW_COLOR: shallow_color_r <= cfg_wdata[RGB_W-1:0];
          REG_MID_COLOR:     mid_color_r     <= cfg_wdata[RGB_W-1:0];
          REG_DEEP_COLOR:    deep_color_r    <= cfg_wdata[RGB_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign busy = busy_r;

  logic accept;
  assign accept = start && !busy_r;

  // --------------------------------------------------------------------------
  // Stage 1: band decision, band length and dither threshold
  // --------------------------------------------------------------------------
  logic [ROW_W-1:0] half_h;
  logic [ROW_W-1:0] low_len;
  logic [YW-1:0]    y_ext;
  band_t            s1_band_nxt;
  logic [ROW_W-1:0] s1_len_nxt;

  logic             s1_vld_r;
  logic [YW-1:0]    s1_y_r;
  band_t            s1_band_r;
  logic [ROW_W-1:0] s1_len_r;
  logic [THR_W-1:0] s1_thr_r;

  assign half_h  = frame_height_r >> 1;
  assign low_len = frame_height_r - half_h;
  assign y_ext   = YW'(in_y_pos);

  always_comb begin
    if (y_ext < YW'(surface_row_r)) begin
      s1_band_nxt = BAND_TOP;
      s1_len_nxt  = surface_row_r;
    end else if (y_ext < YW'(half_h)) begin
      s1_band_nxt = BAND_MID;
      s1_len_nxt  = half_h - surface_row_r;
    end else begin
      s1_band_nxt = BAND_LOW;
      // An empty bottom band (zero frame height) is taken as one row long.
      s1_len_nxt  = (low_len == '0) ? ROW_W'(1) : low_len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_y_r    <= y_ext;
    s1_band_r <= s1_band_nxt;
    s1_len_r  <= s1_len_nxt;
    s1_thr_r  <= DITHER_TAB[{in_y_pos[1:0], in_x_pos[1:0]}];
  end

  // --------------------------------------------------------------------------
  // Stage 2: row offset within the band and per-channel differences
  // --------------------------------------------------------------------------
  logic [YW-1:0]    row_base;
  logic [YW-1:0]    off_full;
  logic [RGB_W-1:0] c_start;
  logic [RGB_W-1:0] c_end;
  logic [ROW_W-1:0] s2_off_nxt;
  logic [CH_W-1:0]  s2_a_nxt   [NUM_CH];
  logic             s2_neg_nxt [NUM_CH];
  logic [CH_W-1:0]  s2_mag_nxt [NUM_CH];

  logic             s2_vld_r;
  logic [ROW_W-1:0] s2_off_r;
  logic [ROW_W-1:0] s2_len_r;
  logic [THR_W-1:0] s2_thr_r;
  logic [CH_W-1:0]  s2_a_r   [NUM_CH];
  logic             s2_neg_r [NUM_CH];
  logic [CH_W-1:0]  s2_mag_r [NUM_CH];

  always_comb begin
    case (s1_band_r)
      BAND_TOP: begin
        row_base = '0;
        c_start  = top_color_r;
        c_end    = shallow_color_r;
      end
      BAND_MID: begin
        row_base = YW'(surface_row_r);
        c_start  = shallow_color_r;
        c_end    = mid_color_r;
      end
      default: begin
        row_base = YW'(half_h);
        c_start  = mid_color_r;
        c_end    = deep_color_r;
      end
    endcase
    off_full = s1_y_r - row_base;
    // Rows past the bottom of the frame hold the deep colour.
    if (off_full > YW'(s1_len_r)) begin
      s2_off_nxt = s1_len_r;
    end else begin
      s2_off_nxt = off_full[ROW_W-1:0];
    end
    for (int k = 0; k < NUM_CH; k++) begin
      s2_a_nxt[k]   = c_start[CH_W*(NUM_CH-1-k) +: CH_W];
      s2_neg_nxt[k] = c_end[CH_W*(NUM_CH-1-k) +: CH_W] < s2_a_nxt[k];
      s2_mag_nxt[k] = s2_neg_nxt[k] ? (s2_a_nxt[k] - c_end[CH_W*(NUM_CH-1-k) +: CH_W])
                                    : (c_end[CH_W*(NUM_CH-1-k) +: CH_W] - s2_a_nxt[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_off_r <= s2_off_nxt;
    s2_len_r <= s1_len_r;
    s2_thr_r <= s1_thr_r;
    for (int k = 0; k < NUM_CH; k++) begin
      s2_a_r[k]   <= s2_a_nxt[k];
      s2_neg_r[k] <= s2_neg_nxt[k];
      s2_mag_r[k] <= s2_mag_nxt[k];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3 (pipe slot 0): |end - start| * offset
  // Pipe slots 1..QW: restoring divider, one quotient bit per slot, MSB first.
  // --------------------------------------------------------------------------
  logic             pv_vld_r [QW+1];
  logic [ROW_W-1:0] pv_len_r [QW+1];
  logic [THR_W-1:0] pv_thr_r [QW+1];
  lane_t            pv_lane_r [QW+1][NUM_CH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_vld_r[0] <= 1'b0;
    end else begin
      pv_vld_r[0] <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    pv_len_r[0] <= s2_len_r;
    pv_thr_r[0] <= s2_thr_r;
    for (int k = 0; k < NUM_CH; k++) begin
      pv_lane_r[0][k].base <= s2_a_r[k];
      pv_lane_r[0][k].neg  <= s2_neg_r[k];
      pv_lane_r[0][k].rem  <= NUM_W'(s2_mag_r[k]) * NUM_W'(s2_off_r);
      pv_lane_r[0][k].quo  <= '0;
    end
  end

  for (genvar g = 0; g < QW; g++) begin : g_div
    localparam int BIT = QW - 1 - g;

    logic [NUM_W-1:0] dvs;
    lane_t            lane_nxt [NUM_CH];

    assign dvs = NUM_W'(pv_len_r[g]) << BIT;

    always_comb begin
      for (int k = 0; k < NUM_CH; k++) begin
        lane_nxt[k] = pv_lane_r[g][k];
        if (pv_lane_r[g][k].rem >= dvs) begin
          lane_nxt[k].rem      = pv_lane_r[g][k].rem - dvs;
          lane_nxt[k].quo[BIT] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pv_vld_r[g+1] <= 1'b0;
      end else begin
        pv_vld_r[g+1] <= pv_vld_r[g];
      end
    end

    always_ff @(posedge clk) begin
      pv_len_r[g+1] <= pv_len_r[g];
      pv_thr_r[g+1] <= pv_thr_r[g];
      for (int k = 0; k < NUM_CH; k++) begin
        pv_lane_r[g+1][k] <= lane_nxt[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: apply sign, add dither, clamp and pack 5-6-5
  // --------------------------------------------------------------------------
  logic signed [CH_W+1:0] dith_sum [NUM_CH];
  logic [CH_W-1:0]        chan     [NUM_CH];
  logic [PIX_W-1:0]       out_pixel_nxt;

  logic                   out_valid_r;
  logic [PIX_W-1:0]       out_pixel_r;

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      // The blended value always lies between the two band colours, so it
      // fits in a channel before the dither offset is added.
      if (pv_lane_r[QW][k].neg) begin
        dith_sum[k] = $signed({2'b00, pv_lane_r[QW][k].base})
                    - $signed({2'b00, pv_lane_r[QW][k].quo});
      end else begin
        dith_sum[k] = $signed({2'b00, pv_lane_r[QW][k].base})
                    + $signed({2'b00, pv_lane_r[QW][k].quo});
      end
      dith_sum[k] = dith_sum[k] + $signed({{(CH_W+2-THR_W){1'b0}}, pv_thr_r[QW]})
                  - (CH_W+2)'(8);
      if (dith_sum[k] < 0) begin
        chan[k] = '0;
      end else if (dith_sum[k] > $signed((CH_W+2)'(255))) begin
        chan[k] = '1;
      end else begin
        chan[k] = dith_sum[k][CH_W-1:0];
      end
    end
    out_pixel_nxt = {chan[0][CH_W-1 -: 5], chan[1][CH_W-1 -: 6], chan[2][CH_W-1 -: 5]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= pv_vld_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    out_pixel_r <= out_pixel_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_rgb565 = out_pixel_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 12))
    else $error("result strobe without a coordinate beat twelve cycles before");

  a_idle_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy raised outside reset");

  a_offset_in_band: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r |-> (s2_len_r != '0) && (s2_off_r <= s2_len_r))
    else $error("row offset outside its band or zero band length");

  a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
    pv_vld_r[QW] |-> (pv_lane_r[QW][0].rem < NUM_W'(pv_len_r[QW]))
                  && (pv_lane_r[QW][1].rem < NUM_W'(pv_len_r[QW]))
                  && (pv_lane_r[QW][2].rem < NUM_W'(pv_len_r[QW])))
    else $error("divider remainder not below the band length");

endmodule
